@@ rtl/queue_move_to_front_rear_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef QUEUE_MOVE_TO_FRONT_REAR_TOP_MACROS_SVH
`define QUEUE_MOVE_TO_FRONT_REAR_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MTFQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mtfq: property failed");

// Next-cycle implication, held off during reset.
`define MTFQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mtfq: property failed");

`endif

@@ rtl/mtfq_pkg.sv @@
`default_nettype none

package mtfq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ      = 2'd0,
        OP_DEQ      = 2'd1,
        OP_TO_FRONT = 2'd2,
        OP_TO_REAR  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_MISS  = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ rtl/mtfq_ram.sv @@
`default_nettype none

module mtfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/queue_move_to_front_rear_top.sv @@
// Channel   Handshake            Payload
// input     in_valid / in_ready  opcode, key
// output    out_valid / out_ready front_key, is_empty, entry_count, status
//
// One command at a time; in_ready is high only while the sequencer is idle.
// Enqueue, dequeue and a move on an empty queue go straight to the front read.
// A move of the entry at position p searches from the front through p, then
// shifts the entries between p and the front or rear; a miss searches all n.
// One RAM read port and one key comparator serve the search and shift steps.
// Reset empties the queue at once; RAM contents need no clearing.
// A stalled result holds the last state; the next command may be taken meanwhile.
`default_nettype none

module queue_move_to_front_rear_top #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic signed [31:0] key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] front_key,
    output logic             is_empty,
    output logic [4:0]       entry_count,
    output logic [1:0]       status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_SEARCH_RD  = 8'b0000_0010,
        S_SEARCH_CMP = 8'b0000_0100,
        S_SHIFT_RD   = 8'b0000_1000,
        S_SHIFT_WR   = 8'b0001_0000,
        S_PUT        = 8'b0010_0000,
        S_FRONT_RD   = 8'b0100_0000,
        S_FRONT_CAP  = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [IW-1:0]           count_reg, count_next;
    logic [AW-1:0]           ptr_reg, ptr_next;
    mtfq_pkg::opcode_t       op_reg, op_next;
    logic [31:0]             key_reg, key_next;
    mtfq_pkg::status_t       sts_reg, sts_next;

    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             front_key_reg, front_key_next;
    logic                    is_empty_reg, is_empty_next;
    logic [4:0]              count_out_reg, count_out_next;
    mtfq_pkg::status_t       status_out_reg, status_out_next;

    mtfq_pkg::opcode_t       in_op;
    logic                    accept;
    logic [AW-1:0]           lidx;
    logic [AW:0]             addr_sum;
    logic [AW-1:0]           addr;
    logic [AW-1:0]           src;
    logic                    at_end;
    logic                    src_end;
    logic [IW-1:0]           count_m1;
    logic [IW-1:0]           ptr_p1;
    logic                    key_hit;
    logic                    we;
    logic [31:0]             wdata;
    logic [31:0]             rdata;
    logic [IW+4:0]           count_wide;

    assign in_op    = mtfq_pkg::opcode_t'(opcode);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign count_m1 = count_reg - IW'(1);
    assign ptr_p1   = IW'(ptr_reg) + IW'(1);
    assign src      = (op_reg == mtfq_pkg::OP_TO_FRONT) ? (ptr_reg - AW'(1))
                                                         : (ptr_reg + AW'(1));
    // end of a shift run: front for to-front, last entry for to-rear
    assign at_end   = (op_reg == mtfq_pkg::OP_TO_FRONT) ? (ptr_reg == '0)
                                                         : (IW'(ptr_reg) == count_m1);
    assign src_end  = (op_reg == mtfq_pkg::OP_TO_FRONT) ? (src == '0)
                                                         : (IW'(src) == count_m1);
    assign key_hit  = (rdata == key_reg);

    // logical position fed to the shared address unit
    always_comb
    begin
        lidx = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                lidx = (in_op == mtfq_pkg::OP_ENQ) ? AW'(count_reg) : AW'(1);
            end
            S_SEARCH_RD, S_SHIFT_WR, S_PUT:
            begin
                lidx = ptr_reg;
            end
            S_SHIFT_RD:
            begin
                lidx = src;
            end
            S_SEARCH_CMP, S_FRONT_RD, S_FRONT_CAP:
            begin
                lidx = '0;
            end
            default:
            begin
                lidx = '0;
            end
        endcase
    end

    // circular buffer: physical = head + logical, wrapped once
    assign addr_sum = {1'b0, head_reg} + {1'b0, lidx};
    assign addr     = (addr_sum >= (AW+1)'(DEPTH)) ? AW'(addr_sum - (AW+1)'(DEPTH))
                                                    : AW'(addr_sum);

    mtfq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        sts_next        = sts_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        front_key_next  = front_key_reg;
        is_empty_next   = is_empty_reg;
        count_out_next  = count_out_reg;
        status_out_next = status_out_reg;
        we              = 1'b0;
        wdata           = key;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    key_next = key;
                    sts_next = mtfq_pkg::STS_DONE;
                    ptr_next = '0;
                    unique case (in_op)
                        mtfq_pkg::OP_ENQ:
                        begin
                            if (count_reg == IW'(DEPTH))
                            begin
                                sts_next = mtfq_pkg::STS_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + IW'(1);
                            end
                            state_next = S_FRONT_RD;
                        end
                        mtfq_pkg::OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next = mtfq_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                head_next  = addr;
                                count_next = count_m1;
                            end
                            state_next = S_FRONT_RD;
                        end
                        mtfq_pkg::OP_TO_FRONT, mtfq_pkg::OP_TO_REAR:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next   = mtfq_pkg::STS_MISS;
                                state_next = S_FRONT_RD;
                            end
                            else
                            begin
                                state_next = S_SEARCH_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FRONT_RD;
                        end
                    endcase
                end
            end
            S_SEARCH_RD:
            begin
                state_next = S_SEARCH_CMP;
            end
            S_SEARCH_CMP:
            begin
                if (key_hit)
                begin
                    state_next = at_end ? S_PUT : S_SHIFT_RD;
                end
                else if (ptr_p1 == count_reg)
                begin
                    sts_next   = mtfq_pkg::STS_MISS;
                    state_next = S_FRONT_RD;
                end
                else
                begin
                    ptr_next   = AW'(ptr_p1);
                    state_next = S_SEARCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                we         = 1'b1;
                wdata      = rdata;
                ptr_next   = src;
                state_next = src_end ? S_PUT : S_SHIFT_RD;
            end
            S_PUT:
            begin
                we         = 1'b1;
                wdata      = key_reg;
                state_next = S_FRONT_RD;
            end
            S_FRONT_RD:
            begin
                state_next = S_FRONT_CAP;
            end
            S_FRONT_CAP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    front_key_next  = (count_reg != '0) ? rdata : '0;
                    is_empty_next   = (count_reg == '0);
                    count_out_next  = count_wide[4:0];
                    status_out_next = sts_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_wide = {5'b0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        sts_reg        <= sts_next;
        front_key_reg  <= front_key_next;
        is_empty_reg   <= is_empty_next;
        count_out_reg  <= count_out_next;
        status_out_reg <= status_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign front_key   = front_key_reg;
    assign is_empty    = is_empty_reg;
    assign entry_count = count_out_reg;
    assign status      = status_out_reg;

endmodule

`default_nettype wire

@@ rtl/mtfq_chk.sv @@
`default_nettype none

`include "queue_move_to_front_rear_top_macros.svh"

module mtfq_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] front_key,
    input wire logic        is_empty,
    input wire logic [4:0]  entry_count,
    input wire logic [1:0]  status
);

    logic [39:0] out_payload;

    assign out_payload = {front_key, is_empty, entry_count, status};

    // a stalled result transaction keeps its payload
    `MTFQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

    // one command at a time: ready drops right after a transaction
    `MTFQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    `MTFQ_ASSERT_IMP(a_empty_fields, clk, rst_n, out_valid && is_empty, {entry_count, front_key} == '0)

    `MTFQ_ASSERT_IMP(a_empty_status, clk, rst_n, out_valid && status == mtfq_pkg::STS_EMPTY, is_empty)

    `MTFQ_ASSERT_IMP(a_full_status, clk, rst_n, out_valid && status == mtfq_pkg::STS_FULL, !is_empty)

endmodule

bind queue_move_to_front_rear_top mtfq_chk u_mtfq_chk (.*);

`default_nettype wire

@@ tb/sv/queue_move_to_front_rear_top_tb.sv @@
`timescale 1ns / 1ps

module queue_move_to_front_rear_top_tb;

    localparam int DEPTH        = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int IDLE_PCT     = 36;
    localparam int POOL_SIZE    = 6;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam int TAIL_CYCLES  = 80;
    localparam int KEY_W        = mtfq_pkg::KEY_W;
    localparam int COUNT_W      = mtfq_pkg::COUNT_W;

    typedef struct {
        mtfq_pkg::opcode_t       op;
        logic signed [KEY_W-1:0] key;
    } command_t;

    typedef struct {
        logic signed [KEY_W-1:0] front_key;
        logic                    is_empty;
        logic [COUNT_W-1:0]      entry_count;
        mtfq_pkg::status_t       status;
    } queue_view_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_MOVE} mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    mtfq_pkg::opcode_t opcode = mtfq_pkg::OP_ENQ;
    logic signed [KEY_W-1:0] key = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [KEY_W-1:0] front_key;
    logic is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0] status;

    // shadow copy of the queue, front at index 0
    logic signed [KEY_W-1:0] shadow_keys [DEPTH];
    int shadow_len = 0;

    command_t pending_cmds[$];
    queue_view_t expected_views[$];
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    logic in_taken = 1'b0;
    logic no_idle = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;

    queue_move_to_front_rear_top #(.DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .front_key   (front_key),
        .is_empty    (is_empty),
        .entry_count (entry_count),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one command to the shadow queue and returns the view after it.
    function automatic queue_view_t apply_command(mtfq_pkg::opcode_t op,
                                                  logic signed [KEY_W-1:0] k);
        queue_view_t view;
        mtfq_pkg::status_t sts;
        int pos;
        int i;
        sts = mtfq_pkg::STS_DONE;
        unique case (op)
            mtfq_pkg::OP_ENQ:
                if (shadow_len >= DEPTH)
                    sts = mtfq_pkg::STS_FULL;
                else
                begin
                    shadow_keys[shadow_len] = k;
                    shadow_len++;
                end
            mtfq_pkg::OP_DEQ:
                if (shadow_len == 0)
                    sts = mtfq_pkg::STS_EMPTY;
                else
                begin
                    for (i = 1; i < shadow_len; i++)
                        shadow_keys[i-1] = shadow_keys[i];
                    shadow_len--;
                end
            default:
            begin
                pos = shadow_len;
                for (i = shadow_len - 1; i >= 0; i--)
                    if (shadow_keys[i] == k)
                        pos = i;
                if (pos >= shadow_len)
                    sts = mtfq_pkg::STS_MISS;
                else if (op == mtfq_pkg::OP_TO_FRONT)
                begin
                    for (i = pos; i > 0; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[0] = k;
                end
                else
                begin
                    for (i = pos + 1; i < shadow_len; i++)
                        shadow_keys[i-1] = shadow_keys[i];
                    shadow_keys[shadow_len-1] = k;
                end
            end
        endcase
        view.front_key   = (shadow_len != 0) ? shadow_keys[0] : '0;
        view.is_empty    = (shadow_len == 0);
        view.entry_count = COUNT_W'(shadow_len);
        view.status      = sts;
        return view;
    endfunction

    function automatic mtfq_pkg::opcode_t pick_opcode(mix_t mix);
        int r;
        int enq_cut;
        int deq_cut;
        int front_cut;
        r = $urandom_range(99);
        unique case (mix)
            MIX_FILL:
            begin
                enq_cut = 50;
                deq_cut = 60;
                front_cut = 80;
            end
            MIX_DRAIN:
            begin
                enq_cut = 15;
                deq_cut = 60;
                front_cut = 80;
            end
            default:
            begin
                enq_cut = 30;
                deq_cut = 50;
                front_cut = 75;
            end
        endcase
        if (r < enq_cut)
            return mtfq_pkg::OP_ENQ;
        else if (r < deq_cut)
            return mtfq_pkg::OP_DEQ;
        else if (r < front_cut)
            return mtfq_pkg::OP_TO_FRONT;
        return mtfq_pkg::OP_TO_REAR;
    endfunction

    // mostly keys from a small pool so that moves hit and duplicates build up
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(POOL_SIZE-1)];
        return $urandom;
    endfunction

    task automatic queue_cmd(mtfq_pkg::opcode_t op, logic signed [KEY_W-1:0] k);
        command_t c;
        c.op = op;
        c.key = k;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0)
            @(posedge clk);
    endtask

    // driver: new transaction only once the previous one has gone
    always @(negedge clk)
    begin : cmd_driver
        command_t c;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_cmds.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                c = pending_cmds.pop_front();
                in_valid <= 1'b1;
                opcode <= c.op;
                key <= c.key;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: results are checked before the command of the same edge is predicted
    always @(posedge clk)
    begin : view_monitor
        queue_view_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result with no command outstanding: front_key %0d", front_key);
                    mismatches++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (front_key !== want.front_key)
                    begin
                        $error("front_key: expected %0d, got %0d", want.front_key, front_key);
                        mismatches++;
                    end
                    if (is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
                        mismatches++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, entry_count);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_views.push_back(apply_command(opcode, key));
            in_taken <= in_valid && in_ready;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic signed [KEY_W-1:0] tail_key;
        int ph;
        int n;
        mix_t mix;

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // empty queue: dequeue and both moves are flagged no-ops
        queue_cmd(mtfq_pkg::OP_DEQ, 32'sd0);
        queue_cmd(mtfq_pkg::OP_TO_FRONT, 32'sd0);
        queue_cmd(mtfq_pkg::OP_TO_REAR, -32'sd1);
        queue_cmd(mtfq_pkg::OP_ENQ, 32'sh8000_0000);
        queue_cmd(mtfq_pkg::OP_ENQ, 32'sh7fff_ffff);
        queue_cmd(mtfq_pkg::OP_ENQ, 32'sd0);
        queue_cmd(mtfq_pkg::OP_ENQ, -32'sd1);
        queue_cmd(mtfq_pkg::OP_ENQ, 32'sh7fff_ffff);
        // duplicates: only the first match from the front moves
        queue_cmd(mtfq_pkg::OP_TO_FRONT, 32'sh7fff_ffff);
        queue_cmd(mtfq_pkg::OP_TO_REAR, 32'sh7fff_ffff);
        queue_cmd(mtfq_pkg::OP_TO_FRONT, 32'sh8000_0000);
        queue_cmd(mtfq_pkg::OP_TO_REAR, 32'sh7fff_ffff);
        queue_cmd(mtfq_pkg::OP_TO_FRONT, -32'sd1);
        // differs from a held key in bit 0 only
        queue_cmd(mtfq_pkg::OP_TO_REAR, 32'sh7fff_fffe);
        for (n = 0; n < 11; n++)
        begin
            tail_key = $urandom;
            queue_cmd(mtfq_pkg::OP_ENQ, tail_key);
        end
        queue_cmd(mtfq_pkg::OP_ENQ, 32'sh5a5a_a5a5);
        queue_cmd(mtfq_pkg::OP_TO_REAR, tail_key);
        queue_cmd(mtfq_pkg::OP_TO_FRONT, tail_key);
        queue_cmd(mtfq_pkg::OP_DEQ, 32'sh1234_5678);
        // hold the sender back until the queue of results is empty
        wait_drained();

        for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;
        for (ph = 0; ph < PHASES; ph++)
        begin
            key_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
            key_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
            if (ph % 2 == 0)
            begin
                key_pool[0] = 32'sh8000_0000;
                key_pool[1] = 32'sh7fff_ffff;
            end
            mix = mix_t'(ph % 3);
            if (ph == 4)
                no_idle = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_cmd(pick_opcode(mix), pick_key());
            if (ph == 4 || ph == 7)
            begin
                wait_drained();
                no_idle = 1'b0;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
